>>> hw/rtl/mrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request receiver package
// Shared frame record, status codes, function codes and the CRC byte update.
// ----------------------------------------------------------------------------
package mrr_pkg;

    localparam logic [7:0]  FN_SINGLE = 8'h06;
    localparam logic [7:0]  FN_MULTI  = 8'h10;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [1:0]  ST_OK      = 2'd0;
    localparam logic [1:0]  ST_CRC     = 2'd1;
    localparam logic [1:0]  ST_STATION = 2'd2;
    localparam logic [1:0]  ST_COUNT   = 2'd3;

    localparam int DATA_SLOTS = 8;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t        station;
        byte_t        func;
        logic [15:0]  address;
        logic [15:0]  quantity;
        logic [15:0]  value;
        byte_t        count;
        logic [63:0]  data;
        logic         crc_ok;
    } frame_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input byte_t b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/mrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request receiver front end
// Parses received bytes, runs the CRC and hands each complete frame onwards.
// ----------------------------------------------------------------------------
module mrr_front
    import mrr_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  byte_t  rx_byte,
    output logic   frame_push,
    input  logic   frame_full,
    output frame_t frame
);

    localparam logic [3:0] PH_STATION = 4'd0;
    localparam logic [3:0] PH_FUNC    = 4'd1;
    localparam logic [3:0] PH_ADDR    = 4'd2;
    localparam logic [3:0] PH_QTY     = 4'd3;
    localparam logic [3:0] PH_VALUE   = 4'd4;
    localparam logic [3:0] PH_COUNT   = 4'd5;
    localparam logic [3:0] PH_DATA    = 4'd6;
    localparam logic [3:0] PH_CRC_LO  = 4'd7;
    localparam logic [3:0] PH_CRC_HI  = 4'd8;

    logic [3:0]  phase_reg, phase_next;
    byte_t       index_reg, index_next;
    byte_t       station_reg, station_next;
    byte_t       func_reg, func_next;
    logic [15:0] address_reg, address_next;
    logic [15:0] quantity_reg, quantity_next;
    logic [15:0] value_reg, value_next;
    byte_t       count_reg, count_next;
    byte_t       store_reg [DATA_SLOTS];
    logic [15:0] crc_reg, crc_next;
    byte_t       crc_lo_reg, crc_lo_next;
    logic        take;
    logic        store_en;
    logic [15:0] crc_upd;
    byte_t       index_inc;

    assign full      = frame_full && (phase_reg == PH_CRC_HI);
    assign take      = push && !full;
    assign crc_upd   = crc_feed(crc_reg, rx_byte);
    assign index_inc = index_reg + 8'd1;
    assign store_en  = take && (phase_reg == PH_DATA) && (index_reg < 8'(DATA_SLOTS))
                       && (int'(index_reg) < MAX_DATA_BYTES);

    always_comb
    begin
        phase_next    = phase_reg;
        index_next    = index_reg;
        station_next  = station_reg;
        func_next     = func_reg;
        address_next  = address_reg;
        quantity_next = quantity_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        frame_push    = 1'b0;
        if (take)
        begin
            case (phase_reg)
                PH_FUNC:
                begin
                    func_next  = rx_byte;
                    crc_next   = crc_upd;
                    index_next = 8'd0;
                    phase_next = PH_ADDR;
                end
                PH_ADDR:
                begin
                    crc_next = crc_upd;
                    if (index_reg == 8'd0)
                    begin
                        address_next = {rx_byte, 8'h00};
                        index_next   = 8'd1;
                    end
                    else
                    begin
                        address_next = {address_reg[15:8], rx_byte};
                        index_next   = 8'd0;
                        phase_next   = (func_reg == FN_SINGLE) ? PH_VALUE : PH_QTY;
                    end
                end
                PH_QTY:
                begin
                    crc_next = crc_upd;
                    if (index_reg == 8'd0)
                    begin
                        quantity_next = {rx_byte, 8'h00};
                        index_next    = 8'd1;
                    end
                    else
                    begin
                        quantity_next = {quantity_reg[15:8], rx_byte};
                        index_next    = 8'd0;
                        phase_next    = (func_reg == FN_MULTI) ? PH_COUNT : PH_CRC_LO;
                    end
                end
                PH_VALUE:
                begin
                    crc_next = crc_upd;
                    if (index_reg == 8'd0)
                    begin
                        value_next = {rx_byte, 8'h00};
                        index_next = 8'd1;
                    end
                    else
                    begin
                        value_next = {value_reg[15:8], rx_byte};
                        index_next = 8'd0;
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_COUNT:
                begin
                    count_next = rx_byte;
                    crc_next   = crc_upd;
                    index_next = 8'd0;
                    phase_next = (rx_byte == 8'd0) ? PH_CRC_LO : PH_DATA;
                end
                PH_DATA:
                begin
                    crc_next = crc_upd;
                    if (index_inc == count_reg)
                    begin
                        index_next = 8'd0;
                        phase_next = PH_CRC_LO;
                    end
                    else
                    begin
                        index_next = index_inc;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    frame_push = 1'b1;
                    index_next = 8'd0;
                    phase_next = PH_STATION;
                end
                default:
                begin
                    station_next = rx_byte;
                    crc_next     = crc_feed(CRC_INIT, rx_byte);
                    index_next   = 8'd0;
                    phase_next   = PH_FUNC;
                end
            endcase
        end
    end

    always_comb
    begin
        frame.station  = station_reg;
        frame.func     = func_reg;
        frame.address  = address_reg;
        frame.quantity = quantity_reg;
        frame.value    = value_reg;
        frame.count    = count_reg;
        for (int k = 0; k < DATA_SLOTS; k++)
        begin
            frame.data[63 - 8 * k -: 8] = store_reg[k];
        end
        frame.crc_ok   = (crc_lo_reg == crc_reg[7:0]) && (rx_byte == crc_reg[15:8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_STATION;
            index_reg    <= 8'd0;
            station_reg  <= 8'd0;
            func_reg     <= 8'd0;
            address_reg  <= 16'd0;
            quantity_reg <= 16'd0;
            value_reg    <= 16'd0;
            count_reg    <= 8'd0;
            crc_reg      <= CRC_INIT;
            crc_lo_reg   <= 8'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            station_reg  <= station_next;
            func_reg     <= func_next;
            address_reg  <= address_next;
            quantity_reg <= quantity_next;
            value_reg    <= value_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_lo_reg   <= crc_lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
            store_reg[index_reg[2:0]] <= rx_byte;
    end

endmodule

>>> hw/rtl/mrr_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request receiver frame queue
// Two-entry queue of parsed frames between the front end and the back end.
// ----------------------------------------------------------------------------
module mrr_fifo
    import mrr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  frame_t wr_data,
    output logic   wr_full,
    input  logic   rd_en,
    output logic   rd_valid,
    output frame_t rd_data
);

    frame_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_full  = (fill_reg == 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !wr_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> hw/rtl/mrr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request receiver back end
// Judges each parsed frame, masks its fields and holds the result for transfer.
// ----------------------------------------------------------------------------
module mrr_back
    import mrr_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  byte_t       station_address,
    input  logic        frame_valid,
    input  frame_t      frame,
    output logic        frame_pop,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  frame_status,
    output byte_t       function_code,
    output logic [15:0] register_address,
    output logic [15:0] register_quantity,
    output logic [15:0] single_write_value,
    output byte_t       byte_count,
    output logic [63:0] write_data
);

    byte_t       station_reg;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  status_reg, status_next;
    byte_t       func_reg;
    logic [15:0] address_reg;
    logic [15:0] quantity_reg, quantity_next;
    logic [15:0] value_reg, value_next;
    byte_t       count_reg, count_next;
    logic [63:0] data_reg, data_next;
    logic        multi;
    logic        single;
    logic        supported;

    assign cfg_ready = 1'b1;
    assign frame_pop = frame_valid && (!out_valid_reg || pop);
    assign multi     = (frame.func == FN_MULTI);
    assign single    = (frame.func == FN_SINGLE);
    assign supported = (frame.count inside {8'd2, 8'd4, 8'd6, 8'd8})
                       && (int'(frame.count) <= MAX_DATA_BYTES);

    always_comb
    begin
        if (frame.station != station_reg)
            status_next = ST_STATION;
        else if (!frame.crc_ok)
            status_next = ST_CRC;
        else if (multi && !supported)
            status_next = ST_COUNT;
        else
            status_next = ST_OK;
        quantity_next = single ? 16'd0 : frame.quantity;
        value_next    = single ? frame.value : 16'd0;
        count_next    = multi ? frame.count : 8'd0;
        for (int k = 0; k < DATA_SLOTS; k++)
        begin
            if (multi && (k < int'(frame.count)) && (k < MAX_DATA_BYTES))
                data_next[63 - 8 * k -: 8] = frame.data[63 - 8 * k -: 8];
            else
                data_next[63 - 8 * k -: 8] = 8'd0;
        end
        if (frame_pop)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_reg   <= 8'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                station_reg <= station_address;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_pop)
        begin
            status_reg   <= status_next;
            func_reg     <= frame.func;
            address_reg  <= frame.address;
            quantity_reg <= quantity_next;
            value_reg    <= value_next;
            count_reg    <= count_next;
            data_reg     <= data_next;
        end
    end

    assign empty              = !out_valid_reg;
    assign frame_status       = status_reg;
    assign function_code      = func_reg;
    assign register_address   = address_reg;
    assign register_quantity  = quantity_reg;
    assign single_write_value = value_reg;
    assign byte_count         = count_reg;
    assign write_data         = data_reg;

endmodule

>>> hw/rtl/modbus_rtu_request_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU request receiver
// Accepts one received byte per clock cycle while full is low and reports one
// judged request per frame, after its last CRC byte. The front end updates the
// CRC-16 with a byte-wide unrolled step, which sets the rate of one byte per
// cycle; full rises only on the last CRC byte of a frame while the two-entry
// frame queue is full. A frame enters the frame queue when its last CRC byte
// is transferred and passes from there to the result register when that
// register is free; the result is held there until popped.
// ----------------------------------------------------------------------------
module modbus_rtu_request_receiver_core
    import mrr_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  frame_status,
    output logic [7:0]  function_code,
    output logic [15:0] register_address,
    output logic [15:0] register_quantity,
    output logic [15:0] single_write_value,
    output logic [7:0]  byte_count,
    output logic [63:0] write_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  station_address
);

    frame_t front_frame;
    frame_t queue_frame;
    logic   front_push;
    logic   queue_full;
    logic   queue_valid;
    logic   back_pop;

    mrr_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .frame_push (front_push),
        .frame_full (queue_full),
        .frame      (front_frame)
    );

    mrr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_frame),
        .wr_full  (queue_full),
        .rd_en    (back_pop),
        .rd_valid (queue_valid),
        .rd_data  (queue_frame)
    );

    mrr_back #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .station_address    (station_address),
        .frame_valid        (queue_valid),
        .frame              (queue_frame),
        .frame_pop          (back_pop),
        .empty              (empty),
        .pop                (pop),
        .frame_status       (frame_status),
        .function_code      (function_code),
        .register_address   (register_address),
        .register_quantity  (register_quantity),
        .single_write_value (single_write_value),
        .byte_count         (byte_count),
        .write_data         (write_data)
    );

endmodule
